FILE: src/ttst_pkg.sv
// ---------------------------------------------------------------------------
// ttst_pkg - shared types and constants of the tx timestamp slot tracker
// Field widths, status and function codes, register indexes and slot sizing.
// ---------------------------------------------------------------------------
package ttst_pkg;

  localparam int NUM_SLOTS = 4;
  localparam int MAX_RETRY = 16;
  localparam int TICK_BITS = 29;

  localparam int SLOT_W     = 2;
  localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int TIME_W     = 64;
  localparam int MARGIN_W   = 16;
  localparam int RETRY_W    = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = MARGIN_W;

  localparam logic [RETRY_W-1:0]  MAX_RETRY_C     = RETRY_W'(MAX_RETRY);
  localparam logic [MARGIN_W-1:0] WRAP_MARGIN_RST = MARGIN_W'(100);

  typedef logic [TICK_BITS-1:0] tick_t;
  typedef logic [TIME_W-1:0]    time_t;

  typedef enum logic [2:0] {
    ST_ARMED    = 3'd0,
    ST_OFF      = 3'd1,
    ST_BUSY     = 3'd2,
    ST_CAPTURED = 3'd3,
    ST_WAITING  = 3'd4,
    ST_GAVE_UP  = 3'd5,
    ST_IDLE     = 3'd6
  } status_t;

  typedef enum logic {
    FUNC_ARM  = 1'b0,
    FUNC_POLL = 1'b1
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TS_ENABLE   = 1'b0,
    CFG_WRAP_MARGIN = 1'b1
  } cfg_idx_t;

endpackage

FILE: src/ttst_in_if.sv
// ---------------------------------------------------------------------------
// ttst_in_if - request channel of the tx timestamp slot tracker
// Valid/ready channel carrying one arm or poll request per transaction.
// ---------------------------------------------------------------------------
interface ttst_in_if
  import ttst_pkg::*;
  ();
  logic                valid;
  logic                ready;
  func_t               func;
  logic [SLOT_W-1:0]   slot;
  time_t               clock_now;
  tick_t               start_tick;
  tick_t               end_tick;
  tick_t               delayed_end_tick;
  logic                retry_policy;
  time_t               captured_stamp;

  modport source (
    output valid, func, slot, clock_now, start_tick, end_tick, delayed_end_tick,
           retry_policy, captured_stamp,
    input  ready
  );

  modport sink (
    input  valid, func, slot, clock_now, start_tick, end_tick, delayed_end_tick,
           retry_policy, captured_stamp,
    output ready
  );
endinterface

FILE: src/ttst_out_if.sv
// ---------------------------------------------------------------------------
// ttst_out_if - result channel of the tx timestamp slot tracker
// Valid/ready channel carrying one status result per transaction.
// ---------------------------------------------------------------------------
interface ttst_out_if
  import ttst_pkg::*;
  ();
  logic              valid;
  logic              ready;
  status_t           status;
  logic [SLOT_W-1:0] slot_out;
  time_t             stamp_out;

  modport source (
    output valid, status, slot_out, stamp_out,
    input  ready
  );

  modport sink (
    input  valid, status, slot_out, stamp_out,
    output ready
  );
endinterface

FILE: src/tx_timestamp_slot_tracker_unit.sv
// ---------------------------------------------------------------------------
// tx_timestamp_slot_tracker_unit - transmit timestamp capture slot tracker
// Arms slots with rebuilt send windows and polls them for a new hw stamp.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch carries one request per transaction: func selects arm or poll of
//   a slot, with the current clock, the send-window ticks and the stamp read
//   from the slot's hardware timestamp register.
//   out_ch returns exactly one result per request, in order: status, the
//   slot and the captured stamp (zero unless the status is captured).
//   cfg_we/cfg_index/cfg_wdata write timestamp_enable (index 0) and
//   wrap_margin (index 1); write them only while no request is in flight.
// Timing:
//   a request is held in the input register, where its slot state is read
//   and updated; the result is then loaded into the output register once
//   that register is free or being drained, and out_ch.valid rises with it.
//   One request per cycle is sustained while out_ch.ready stays high; the
//   per-slot state update in the input stage is visible to the very next request.
// Reset (rst_n low, synchronous): all slots free, stamps and retry counts
//   zero, timestamping off, wrap_margin 100.
// Back-pressure: with out_ch.ready low the output register holds its result,
//   the input register fills, and in_ch.ready drops until out_ch drains.
// ---------------------------------------------------------------------------
module tx_timestamp_slot_tracker_unit
  import ttst_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  ttst_in_if.sink               in_ch,
  ttst_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // join a tick to the clock's upper bits, one wrap added if well behind
  function automatic time_t rebuild_time(input time_t clk_v, input tick_t tick,
                                         input logic [MARGIN_W-1:0] margin);
    tick_t                    low;
    tick_t                    diff;
    logic [TIME_W-TICK_BITS-1:0] upper;
    logic                     wrap;
    low   = clk_v[TICK_BITS-1:0];
    diff  = low - tick;
    wrap  = (low > tick) && ({{(TIME_W-TICK_BITS){1'b0}}, diff} >
                             {{(TIME_W-MARGIN_W){1'b0}}, margin});
    upper = clk_v[TIME_W-1:TICK_BITS] + {{(TIME_W-TICK_BITS-1){1'b0}}, wrap};
    return {upper, tick};
  endfunction

  // configuration
  logic                ts_enable_r;
  logic [MARGIN_W-1:0] wrap_margin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_enable_r   <= 1'b0;
      wrap_margin_r <= WRAP_MARGIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TS_ENABLE:   ts_enable_r   <= cfg_wdata[0];
        CFG_WRAP_MARGIN: wrap_margin_r <= cfg_wdata[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic              in_v_r;
  func_t             in_func_r;
  logic [SLOT_W-1:0] in_slot_r;
  time_t             in_clock_r;
  tick_t             in_start_r;
  tick_t             in_end_r;
  tick_t             in_delayed_r;
  logic              in_retry_r;
  time_t             in_stamp_r;

  // output register
  logic              out_v_r;
  status_t           out_status_r;
  logic [SLOT_W-1:0] out_slot_r;
  time_t             out_stamp_r;

  logic adv;
  logic in_take;

  assign adv      = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || adv;
  assign in_take  = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_take) begin
      in_v_r <= 1'b1;
    end else if (adv) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_func_r    <= in_ch.func;
      in_slot_r    <= in_ch.slot;
      in_clock_r   <= in_ch.clock_now;
      in_start_r   <= in_ch.start_tick;
      in_end_r     <= in_ch.end_tick;
      in_delayed_r <= in_ch.delayed_end_tick;
      in_retry_r   <= in_ch.retry_policy;
      in_stamp_r   <= in_ch.captured_stamp;
    end
  end

  // per-slot state
  logic [NUM_SLOTS-1:0] slot_busy_r, slot_busy_nxt;
  time_t                start_after_r [NUM_SLOTS];
  time_t                wait_until_r  [NUM_SLOTS];
  time_t                last_stamp_r  [NUM_SLOTS];
  logic [RETRY_W-1:0]   retry_count_r [NUM_SLOTS];

  logic [SLOT_IDX_W-1:0] idx;
  logic                  slot_ok;
  logic                  busy_sel;
  logic [RETRY_W-1:0]    retry_inc;
  tick_t                 deadline_tick;
  time_t                 start_full;
  time_t                 deadline_full;

  status_t               status_nxt;
  time_t                 stamp_nxt;
  logic                  arm_wr;
  logic                  stamp_wr;
  logic                  retry_wr;
  logic [RETRY_W-1:0]    retry_val;

  assign idx           = SLOT_IDX_W'(in_slot_r);
  assign slot_ok       = int'(in_slot_r) < NUM_SLOTS;
  assign busy_sel      = slot_ok && slot_busy_r[idx];
  assign retry_inc     = retry_count_r[idx] + RETRY_W'(1);
  assign deadline_tick = in_retry_r ? in_delayed_r : in_end_r;
  assign start_full    = rebuild_time(in_clock_r, in_start_r, wrap_margin_r);
  assign deadline_full = rebuild_time(in_clock_r, deadline_tick, wrap_margin_r);

  always_comb begin
    status_nxt    = ST_IDLE;
    stamp_nxt     = '0;
    arm_wr        = 1'b0;
    stamp_wr      = 1'b0;
    retry_wr      = 1'b0;
    retry_val     = '0;
    slot_busy_nxt = slot_busy_r;
    if (in_func_r == FUNC_ARM) begin
      if (!ts_enable_r) begin
        status_nxt = ST_OFF;
      end else if (!slot_ok || slot_busy_r[idx]) begin
        status_nxt = ST_BUSY;
      end else begin
        status_nxt         = ST_ARMED;
        arm_wr             = 1'b1;
        slot_busy_nxt[idx] = 1'b1;
      end
    end else if (!slot_ok) begin
      status_nxt = ST_IDLE;
    end else if (!busy_sel) begin
      status_nxt = ST_IDLE;
      retry_wr   = 1'b1;
    end else if (in_clock_r < start_after_r[idx]) begin
      status_nxt = ST_WAITING;
    end else if (in_stamp_r == last_stamp_r[idx]) begin
      if (in_clock_r < wait_until_r[idx]) begin
        status_nxt = ST_WAITING;
      end else if (retry_inc >= MAX_RETRY_C) begin
        status_nxt         = ST_GAVE_UP;
        retry_wr           = 1'b1;
        slot_busy_nxt[idx] = 1'b0;
      end else begin
        status_nxt = ST_WAITING;
        retry_wr   = 1'b1;
        retry_val  = retry_inc;
      end
    end else begin
      status_nxt         = ST_CAPTURED;
      stamp_nxt          = in_stamp_r;
      stamp_wr           = 1'b1;
      retry_wr           = 1'b1;
      slot_busy_nxt[idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_busy_r <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        last_stamp_r[i]  <= '0;
        retry_count_r[i] <= '0;
      end
    end else if (adv) begin
      slot_busy_r <= slot_busy_nxt;
      if (stamp_wr) begin
        last_stamp_r[idx] <= in_stamp_r;
      end
      if (retry_wr) begin
        retry_count_r[idx] <= retry_val;
      end
    end
  end

  // window times are only read while the slot is busy, so no reset
  always_ff @(posedge clk) begin
    if (adv && arm_wr) begin
      start_after_r[idx] <= start_full;
      wait_until_r[idx]  <= deadline_full;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_status_r <= status_nxt;
      out_slot_r   <= in_slot_r;
      out_stamp_r  <= stamp_nxt;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.slot_out  = out_slot_r;
  assign out_ch.stamp_out = out_stamp_r;

endmodule
